### rtl/lbs_pkg.sv
package lbs_pkg;

   localparam int MAX_BONES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_INFL = 1'b1;

   // one classified beat as it travels from front to back
   typedef struct packed {
      logic               is_load;
      logic               oob;
      logic [5:0]         bone;
      logic [1:0]         row;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      logic               blended;
      logic               last;
   } item_type;

endpackage

### rtl/lbs_front.sv
module lbs_front #(
   parameter int MAX_BONES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [5:0]         req_bone,
   input  logic [1:0]         req_row,
   input  logic signed [31:0] req_value_a,
   input  logic signed [31:0] req_value_b,
   input  logic signed [31:0] req_value_c,
   input  logic signed [31:0] req_value_d,
   input  logic               req_blended,
   input  logic               req_last,
   output logic               q_valid,
   output lbs_pkg::item_type  q_item,
   input  logic               q_pop
);
   import lbs_pkg::*;

   item_type   fifo_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   item_type   cls;
   logic       push, pop;

   // classify the incoming beat
   always_comb begin
      cls.is_load = (req_cmd == CMD_LOAD);
      cls.oob     = (32'(req_bone) >= MAX_BONES);
      cls.bone    = req_bone;
      cls.row     = req_row;
      cls.a       = req_value_a;
      cls.b       = req_value_b;
      cls.c       = req_value_c;
      cls.d       = req_value_d;
      cls.blended = req_blended;
      cls.last    = req_last;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop & q_valid;
   assign q_item    = fifo_ff[rp_ff];

   // two-entry queue
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= cls;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### rtl/lbs_back.sv
module lbs_back #(
   parameter int MAX_BONES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lbs_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic               rsp_w_zero
);
   import lbs_pkg::*;

   localparam int DEPTH  = MAX_BONES * 4;
   localparam int ROW_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW     = 97;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_MUL, S_ACC, S_DSET, S_DIV, S_DFIX, S_WMUL, S_WFIX, S_SUM, S_EMIT
   } state_type;

   logic [127:0]       mem [DEPTH];
   logic [127:0]       rd_ff;
   logic               rd_en;
   logic [ROW_AW-1:0]  rd_addr;

   state_type          state_ff;
   item_type           item_ff;
   logic [1:0]         rowi_ff, col_ff, coord_ff;
   logic signed [63:0] acc_ff [4];
   logic signed [63:0] prod_ff;
   logic [DW-1:0]      rem_ff, dsh_ff;
   logic [32:0]        q_ff;
   logic               ovf_ff, neg_ff;
   logic [5:0]         iter_ff;
   logic signed [31:0] r_ff;
   logic signed [31:0] sum_ff [3];
   logic               zw_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic               pw_ff;

   logic signed [31:0] elem, pnt;
   logic signed [63:0] n_val, w_val;
   logic [63:0]        an, aw;
   logic [DW-1:0]      dvd, dsh0;
   logic signed [32:0] sum_ext;

   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   assign q_pop      = (state_ff == S_IDLE) & q_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = px_ff;
   assign rsp_pos_y  = py_ff;
   assign rsp_pos_z  = pz_ff;
   assign rsp_w_zero = pw_ff;

   // matrix element and point operand for the multiplier
   always_comb begin
      elem = item_ff.oob ? 32'sd0 : $signed(rd_ff[32*col_ff +: 32]);
      case (rowi_ff)
         2'd0:    pnt = item_ff.a;
         2'd1:    pnt = item_ff.b;
         default: pnt = item_ff.c;
      endcase
   end

   // divider setup operands
   always_comb begin
      n_val   = acc_ff[coord_ff];
      w_val   = acc_ff[3];
      an      = n_val[63] ? 64'(-n_val) : 64'(n_val);
      aw      = w_val[63] ? 64'(-w_val) : 64'(w_val);
      dvd     = DW'(an) << FRAC_BITS;
      dsh0    = DW'(aw) << 32;
      sum_ext = 33'(sum_ff[coord_ff]) + 33'(r_ff);
   end

   // table read port, next row fetched once the current row is done
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ROW_AW'({q_item.bone, 2'd3});
      if (state_ff == S_IDLE) begin
         rd_en   = q_valid & ~q_item.is_load;
         rd_addr = ROW_AW'({q_item.bone, 2'd3});
      end else if (state_ff == S_INIT) begin
         rd_en   = 1'b1;
         rd_addr = ROW_AW'({item_ff.bone, 2'd0});
      end else if (state_ff == S_ACC && col_ff == 2'd3) begin
         rd_en   = 1'b1;
         rd_addr = ROW_AW'({item_ff.bone, 2'(rowi_ff + 2'd1)});
      end
   end

   // bone table, one matrix row per entry
   always_ff @(posedge clock) begin
      if (q_pop && q_item.is_load && !q_item.oob) begin
         mem[ROW_AW'({q_item.bone, q_item.row})] <= {q_item.d, q_item.c, q_item.b, q_item.a};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         zw_ff        <= 1'b0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= 32'sd0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid && !q_item.is_load) begin
                  item_ff  <= q_item;
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               for (int i = 0; i < 4; i++) begin
                  acc_ff[i] <= item_ff.oob ? 64'sd0 : 64'($signed(rd_ff[32*i +: 32]));
               end
               rowi_ff  <= 2'd0;
               col_ff   <= 2'd0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= pnt * elem;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff[col_ff] <= acc_ff[col_ff] + (prod_ff >>> FRAC_BITS);
               col_ff <= col_ff + 2'd1;
               if (col_ff == 2'd3) begin
                  if (rowi_ff == 2'd2) begin
                     coord_ff <= 2'd0;
                     state_ff <= S_DSET;
                  end else begin
                     rowi_ff  <= rowi_ff + 2'd1;
                     state_ff <= S_MUL;
                  end
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_DSET: begin
               if (w_val == 64'sd0) begin
                  zw_ff <= 1'b1;
                  if (n_val > 64'sd0) r_ff <= 32'sh7fffffff;
                  else if (n_val < 64'sd0) r_ff <= 32'sh80000000;
                  else r_ff <= 32'sd0;
                  state_ff <= item_ff.blended ? S_WMUL : S_SUM;
               end else begin
                  rem_ff   <= dvd;
                  dsh_ff   <= dsh0;
                  ovf_ff   <= ((dvd >> 1) >= dsh0);
                  neg_ff   <= n_val[63] ^ w_val[63];
                  q_ff     <= 33'd0;
                  iter_ff  <= 6'd32;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // one quotient bit per cycle
               if (rem_ff >= dsh_ff) begin
                  rem_ff <= rem_ff - dsh_ff;
                  q_ff   <= {q_ff[31:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[31:0], 1'b0};
               end
               dsh_ff  <= dsh_ff >> 1;
               iter_ff <= iter_ff - 6'd1;
               if (iter_ff == 6'd0) state_ff <= S_DFIX;
            end
            S_DFIX: begin
               if (neg_ff) begin
                  if (ovf_ff || q_ff[32] || (q_ff[31:0] > 32'h80000000)) r_ff <= 32'sh80000000;
                  else r_ff <= $signed(32'(-q_ff[31:0]));
               end else begin
                  if (ovf_ff || q_ff[32] || q_ff[31]) r_ff <= 32'sh7fffffff;
                  else r_ff <= $signed(q_ff[31:0]);
               end
               state_ff <= item_ff.blended ? S_WMUL : S_SUM;
            end
            S_WMUL: begin
               prod_ff  <= r_ff * item_ff.d;
               state_ff <= S_WFIX;
            end
            S_WFIX: begin
               r_ff     <= sat64(prod_ff >>> FRAC_BITS);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (sum_ext[32] != sum_ext[31]) begin
                  sum_ff[coord_ff] <= sum_ext[32] ? 32'sh80000000 : 32'sh7fffffff;
               end else begin
                  sum_ff[coord_ff] <= sum_ext[31:0];
               end
               if (coord_ff == 2'd2) begin
                  state_ff <= item_ff.last ? S_EMIT : S_IDLE;
               end else begin
                  coord_ff <= coord_ff + 2'd1;
                  state_ff <= S_DSET;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  px_ff        <= sum_ff[0];
                  py_ff        <= sum_ff[1];
                  pz_ff        <= sum_ff[2];
                  pw_ff        <= zw_ff;
                  zw_ff        <= 1'b0;
                  for (int i = 0; i < 3; i++) sum_ff[i] <= 32'sd0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/linear_blend_skinning_top.sv
// a matrix-row load is written to the bone table in the back end, after the 2-beat queue
// an influence runs 32x32 multiply-accumulate over the matrix rows, then for each coordinate
// a bit-serial divide by w in the divider, followed by a weight multiply when blended;
// the sums are emitted on the last beat; a zero w skips the divider
// the back end works on one beat at a time; the queue takes 2 beats ahead
// reset: synchronous, clears control, sums and flags; the bone table is not cleared
module linear_blend_skinning_top #(
   parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [5:0]         req_bone,
   input  logic [1:0]         req_row,
   input  logic signed [31:0] req_value_a,
   input  logic signed [31:0] req_value_b,
   input  logic signed [31:0] req_value_c,
   input  logic signed [31:0] req_value_d,
   input  logic               req_blended,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic               rsp_w_zero
);
   import lbs_pkg::*;

   logic     q_valid, q_pop;
   item_type q_item;

   // front: accept and classify
   lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_bone, .req_row,
      .req_value_a, .req_value_b, .req_value_c, .req_value_d, .req_blended, .req_last,
      .q_valid, .q_item, .q_pop
   );

   // back: table, transform, divide, blend
   lbs_back #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_ready, .rsp_pos_x, .rsp_pos_y, .rsp_pos_z, .rsp_w_zero
   );

endmodule
